// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Types and constants shared by the bracket pair matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int STACK_DEPTH   = 32;
  localparam int POSITION_BITS = 16;
  localparam int STACK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STACK_CNT_W   = $clog2(STACK_DEPTH + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_OPEN_CHAR  = 1'b0;
  localparam logic REG_CLOSE_CHAR = 1'b1;

  localparam logic [7:0] OPEN_CHAR_RST  = 8'd123;
  localparam logic [7:0] CLOSE_CHAR_RST = 8'd125;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;

  typedef enum logic [2:0] {
    ST_PAIR      = 3'd0,
    ST_STRAY     = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_END_CLEAN = 3'd3,
    ST_END_ERROR = 3'd4
  } bpm_status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } bpm_in_t;

  typedef struct packed {
    bpm_status_t              status;
    logic [POSITION_BITS-1:0] open_position;
    logic [POSITION_BITS-1:0] close_position;
    logic                     last_of_run;
  } bpm_out_t;

  // results produced by one character, in delivery order
  typedef struct packed {
    logic [1:0] count;
    bpm_out_t   first;
    bpm_out_t   second;
  } bpm_push_t;

endpackage

// File: src/bpm_scan.sv
// ----------------------------------------------------------------------------
// bpm_scan
// Lexical state, position counter and open-position stack; turns one
// character into zero, one or two results.
// ----------------------------------------------------------------------------
module bpm_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  bpm_pkg::bpm_in_t item,
  input  logic [7:0]       open_char,
  input  logic [7:0]       close_char,
  output bpm_pkg::bpm_push_t push
);

  logic [bpm_pkg::POSITION_BITS-1:0] pos_r;
  logic [bpm_pkg::POSITION_BITS-1:0] stack_r [bpm_pkg::STACK_DEPTH];
  logic [bpm_pkg::STACK_CNT_W-1:0]   cnt_r, cnt_nxt, top_cnt;
  logic comment_r, comment_nxt;
  logic lit_r, lit_nxt;
  logic single_r, single_nxt;
  logic bs_odd_r, bs_odd_nxt;
  logic slash_r, slash_nxt;
  logic err_r, err_nxt;

  logic [7:0] c;
  logic       check, is_quote;
  logic       is_open, is_close, full, empty, do_push, do_pop, event_hit;
  bpm_pkg::bpm_out_t ev_res, end_res;

  assign c        = item.text_byte;
  assign is_quote = (c == bpm_pkg::CH_DQUOTE) || (c == bpm_pkg::CH_SQUOTE);
  assign top_cnt  = cnt_r - bpm_pkg::STACK_CNT_W'(1);

  always_comb begin
    check       = 1'b1;
    comment_nxt = comment_r;
    lit_nxt     = lit_r;
    single_nxt  = single_r;
    slash_nxt   = slash_r;
    bs_odd_nxt  = (c == bpm_pkg::CH_BACKSLASH) ? !bs_odd_r : 1'b0;
    priority if (comment_r) begin
      if (c == bpm_pkg::CH_NEWLINE) begin
        comment_nxt = 1'b0;
      end
      check = 1'b0;
    end else if (is_quote && !bs_odd_r) begin
      if (lit_r) begin
        if ((c == bpm_pkg::CH_SQUOTE) == single_r) begin
          lit_nxt = 1'b0;
        end
      end else begin
        lit_nxt    = 1'b1;
        single_nxt = (c == bpm_pkg::CH_SQUOTE);
      end
      slash_nxt = 1'b0;
    end else if (lit_r) begin
      check = 1'b0;
    end else if ((c == bpm_pkg::CH_SLASH) && slash_r) begin
      comment_nxt = 1'b1;
      slash_nxt   = 1'b0;
      check       = 1'b0;
    end else begin
      slash_nxt = (c == bpm_pkg::CH_SLASH);
    end
  end

  always_comb begin
    is_open   = check && (c == open_char);
    is_close  = check && !is_open && (c == close_char);
    full      = (cnt_r == bpm_pkg::STACK_CNT_W'(bpm_pkg::STACK_DEPTH));
    empty     = (cnt_r == '0);
    do_push   = is_open && !full;
    do_pop    = is_close && !empty;
    event_hit = (is_open && full) || is_close;

    cnt_nxt = cnt_r;
    if (do_push) begin
      cnt_nxt = cnt_r + bpm_pkg::STACK_CNT_W'(1);
    end else if (do_pop) begin
      cnt_nxt = top_cnt;
    end
    err_nxt = err_r || (is_open && full) || (is_close && empty);

    if (is_open) begin
      ev_res.status = bpm_pkg::ST_OVERFLOW;
    end else if (empty) begin
      ev_res.status = bpm_pkg::ST_STRAY;
    end else begin
      ev_res.status = bpm_pkg::ST_PAIR;
    end
    ev_res.open_position  = do_pop ? stack_r[top_cnt[bpm_pkg::STACK_IDX_W-1:0]] : '0;
    ev_res.close_position = pos_r;
    ev_res.last_of_run    = !item.end_of_text;

    end_res.status         = ((cnt_nxt == '0) && !err_nxt) ? bpm_pkg::ST_END_CLEAN
                                                           : bpm_pkg::ST_END_ERROR;
    end_res.open_position  = '0;
    end_res.close_position = pos_r;
    end_res.last_of_run    = 1'b1;

    push.first  = event_hit ? ev_res : end_res;
    push.second = end_res;
    if (!go) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, event_hit} + {1'b0, item.end_of_text};
    end
  end

  always_ff @(posedge clk) begin
    if (go && do_push) begin
      stack_r[cnt_r[bpm_pkg::STACK_IDX_W-1:0]] <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      cnt_r     <= '0;
      comment_r <= 1'b0;
      lit_r     <= 1'b0;
      single_r  <= 1'b0;
      bs_odd_r  <= 1'b0;
      slash_r   <= 1'b0;
      err_r     <= 1'b0;
    end else if (go) begin
      if (item.end_of_text) begin
        pos_r     <= '0;
        cnt_r     <= '0;
        comment_r <= 1'b0;
        lit_r     <= 1'b0;
        single_r  <= 1'b0;
        bs_odd_r  <= 1'b0;
        slash_r   <= 1'b0;
        err_r     <= 1'b0;
      end else begin
        pos_r     <= pos_r + bpm_pkg::POSITION_BITS'(1);
        cnt_r     <= cnt_nxt;
        comment_r <= comment_nxt;
        lit_r     <= lit_nxt;
        single_r  <= single_nxt;
        bs_odd_r  <= bs_odd_nxt;
        slash_r   <= slash_nxt;
        err_r     <= err_nxt;
      end
    end
  end

endmodule

// File: src/bracket_pair_matcher_unit.sv
// ----------------------------------------------------------------------------
// bracket_pair_matcher_unit
// Streams source text, skips comments and quoted literals, and reports
// matched bracket pairs, stray closes, overflow and an end status.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_ready  | bpm_in_t  (one character)
//   out_    | out       | out_valid/out_ready  | bpm_out_t (one result)
//   cfg     | in        | APB psel/penable     | open_char, close_char
//
// One character per cycle while there is room; an accepted character is
// scanned from the input register once two buffer slots are free, and its
// results enter the buffer at the edge that ends that scan.
// Results queue in a 4-entry buffer; input stalls when fewer than 2 slots
// are free, so throughput falls below one per cycle only when the output
// side stalls or characters average more than one result.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_pair_matcher_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpm_pkg::bpm_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpm_pkg::bpm_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpm_pkg::DATA_W-1:0]    pwdata,
  output logic [bpm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [7:0] open_char_r, close_char_r;
  logic       s1_v_r, s1_v_nxt;
  bpm_pkg::bpm_in_t   s1_item_r;
  bpm_pkg::bpm_push_t push;
  bpm_pkg::bpm_out_t  fifo_r [bpm_pkg::FIFO_DEPTH];
  logic [bpm_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bpm_pkg::FIFO_CNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic room, scan_go, in_fire, out_fire, cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bpm_pkg::REG_CLOSE_CHAR) ? {24'd0, close_char_r}
                                                        : {24'd0, open_char_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_char_r  <= bpm_pkg::OPEN_CHAR_RST;
      close_char_r <= bpm_pkg::CLOSE_CHAR_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == bpm_pkg::REG_CLOSE_CHAR) begin
        close_char_r <= pwdata[7:0];
      end else begin
        open_char_r <= pwdata[7:0];
      end
    end
  end

  // input register
  assign room     = (fifo_cnt_r <= bpm_pkg::FIFO_CNT_W'(bpm_pkg::FIFO_DEPTH - 2));
  assign scan_go  = s1_v_r && room;
  assign in_ready = !s1_v_r || room;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (scan_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  bpm_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (scan_go),
    .item       (s1_item_r),
    .open_char  (open_char_r),
    .close_char (close_char_r),
    .push       (push)
  );

  // result buffer
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign out_fire  = out_valid && out_ready;
  assign fifo_cnt_nxt = fifo_cnt_r + bpm_pkg::FIFO_CNT_W'(push.count)
                        - bpm_pkg::FIFO_CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      fifo_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      fifo_r[wr_ptr_r + bpm_pkg::FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + bpm_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_r   <= rd_ptr_r + bpm_pkg::FIFO_PTR_W'(out_fire);
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_fifo_bound, fifo_cnt_r > bpm_pkg::FIFO_CNT_W'(bpm_pkg::FIFO_DEPTH), "overrun")
  `ASSERT_ALWAYS(a_push_room, (push.count != 2'd0) |-> room, "push without two free slots")
  `ASSERT_ALWAYS(a_end_result, (scan_go && s1_item_r.end_of_text) |=> out_valid, "no end result")

endmodule
